// ===== design/vtzd_pkg.sv =====
// Shared types and constants for the vertex transform with z divide.
// Used by the transform front end, the divider cells and the top level.
`timescale 1ns / 1ps

package vtzd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_COEF      = 12;
    localparam int DIV_STEPS     = 32;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // One output component on its way through the divider chain
    typedef struct packed {
        logic [31:0] rem;     // partial remainder, below the divisor unless the lane is fixed
        logic [31:0] low;     // dividend bits not yet shifted in
        logic [31:0] quo;     // quotient bits collected so far
        logic        neg;     // quotient sign
        logic        fixed;   // result already known, divider output ignored
        logic        sat;     // fixed result is a saturation
        logic [31:0] fixval;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] ln;
        logic [31:0] dm;      // divisor magnitude
        logic [31:0] w;
        logic        zdiv;
    } item_t;

endpackage

// ===== design/vtzd_xform.sv =====
// Matrix store, products, column sums and divider setup for the z divide block.
// Depends on vtzd_pkg.
`timescale 1ns / 1ps

module vtzd_xform import vtzd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_fire,
    input  logic               cmd,
    input  logic [3:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] vz,
    input  logic               div_en,
    output logic               prep_vld,
    output item_t              prep_item
);

    localparam int TW = 66 - FRAC_BITS;
    localparam int SH = 32 - FRAC_BITS;
    localparam logic signed [TW-1:0] T_MAX = TW'(S32_MAX);
    localparam logic signed [TW-1:0] T_MIN = TW'(S32_MIN);

    logic signed [31:0] coef_reg [NUM_COEF];

    logic               p_vld_reg;
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] prod_next [3][3];
    logic signed [31:0] trans_reg [3];
    logic signed [31:0] z1_reg;
    logic               den1_reg;

    logic               t_vld_reg;
    logic signed [TW-1:0] t_reg [3];
    logic signed [TW-1:0] t_next [3];
    logic signed [31:0] z2_reg;
    logic               den2_reg;

    logic               prep_vld_reg;
    item_t              prep_reg;
    item_t              prep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (in_fire && cmd == CMD_LOAD && coef_index < 4'(NUM_COEF))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c][0] = vx * coef_reg[c];
            prod_next[c][1] = vy * coef_reg[3 + c];
            prod_next[c][2] = vz * coef_reg[6 + c];
        end
    end

    always_comb
    begin
        logic signed [64:0] s;
        for (int c = 0; c < 3; c++)
        begin
            s = 65'(prod_reg[c][0]) + 65'(prod_reg[c][1]) + 65'(prod_reg[c][2]);
            t_next[c] = TW'(s >>> FRAC_BITS) + TW'(trans_reg[c]);
        end
    end

    always_comb
    begin
        logic [TW-1:0] mag;
        logic [TW-1:0] lim;
        logic          neg;
        logic [31:0]   dm;
        logic signed [TW-1:0] tv;
        dm = z2_reg[31] ? 32'(-z2_reg) : 32'(z2_reg);
        prep_next      = '0;
        prep_next.dm   = dm;
        prep_next.w    = z2_reg;
        prep_next.zdiv = den2_reg && (z2_reg == '0);
        for (int c = 0; c < 3; c++)
        begin
            tv  = t_reg[c];
            neg = tv[TW-1] ^ z2_reg[31];
            mag = tv[TW-1] ? TW'(-tv) : TW'(tv);
            lim = {{(TW-32){1'b0}}, dm} << SH;
            prep_next.ln[c].neg = neg;
            prep_next.ln[c].rem = mag[SH+31:SH];
            prep_next.ln[c].low = {mag[SH-1:0], {FRAC_BITS{1'b0}}};
            if (!den2_reg)
            begin
                prep_next.ln[c].fixed = 1'b1;
                if (tv > T_MAX)
                begin
                    prep_next.ln[c].fixval = S32_MAX;
                    prep_next.ln[c].sat    = 1'b1;
                end
                else if (tv < T_MIN)
                begin
                    prep_next.ln[c].fixval = S32_MIN;
                    prep_next.ln[c].sat    = 1'b1;
                end
                else
                begin
                    prep_next.ln[c].fixval = tv[31:0];
                end
            end
            else if (z2_reg == '0)
            begin
                prep_next.ln[c].fixed  = 1'b1;
                prep_next.ln[c].sat    = (tv != '0);
                prep_next.ln[c].fixval = (tv == '0) ? 32'd0 : (tv[TW-1] ? S32_MIN : S32_MAX);
            end
            else if (mag >= lim)
            begin
                // quotient would need more than 32 bits
                prep_next.ln[c].fixed  = 1'b1;
                prep_next.ln[c].sat    = 1'b1;
                prep_next.ln[c].fixval = neg ? S32_MIN : S32_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg    <= 1'b0;
            t_vld_reg    <= 1'b0;
            prep_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg    <= in_fire && cmd == CMD_VERTEX;
            t_vld_reg    <= p_vld_reg;
            prep_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            for (int c = 0; c < 3; c++)
            begin
                trans_reg[c] <= coef_reg[9 + c];
            end
            z1_reg    <= vz;
            den1_reg  <= div_en;
            t_reg     <= t_next;
            z2_reg    <= z1_reg;
            den2_reg  <= den1_reg;
            prep_reg  <= prep_next;
        end
    end

    assign prep_vld  = prep_vld_reg;
    assign prep_item = prep_reg;

endmodule

// ===== design/vtzd_div_cell.sv =====
// One restoring divide step for all three components, registered.
// Depends on vtzd_pkg.
`timescale 1ns / 1ps

module vtzd_div_cell import vtzd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_vld,
    input  item_t in_item,
    output logic  out_vld,
    output item_t out_item
);

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;

    always_comb
    begin
        logic [32:0] t;
        item_next = in_item;
        for (int c = 0; c < 3; c++)
        begin
            t = {in_item.ln[c].rem, in_item.ln[c].low[31]};
            item_next.ln[c].low = {in_item.ln[c].low[30:0], 1'b0};
            if (t >= {1'b0, in_item.dm})
            begin
                item_next.ln[c].rem = 32'(t - {1'b0, in_item.dm});
                item_next.ln[c].quo = {in_item.ln[c].quo[30:0], 1'b1};
            end
            else
            begin
                item_next.ln[c].rem = t[31:0];
                item_next.ln[c].quo = {in_item.ln[c].quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ===== design/vertex_transform_z_divide.sv =====
// Top level of the affine vertex transform with optional divide by z.
// Depends on vtzd_pkg, vtzd_xform and vtzd_div_cell.
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_ready): cmd 1 loads coef_value into slot coef_index
// (slots above 11 are dropped) and gives no result; cmd 0 transforms vx, vy, vz.
// Output channel (out_valid/out_ready): one transaction per vertex with out_x,
// out_y, out_z, out_w = vz and the zero_divisor and overflowed flags.
// cfg_we/cfg_wdata write divide_enable; write it only while the block is idle.
// Throughput: one transaction per cycle while out_ready does not stall the pipe. From input accept
// to out_valid a vertex passes the products, column sum, divider setup, 32 divider cells
// and the output register; the 32 one-bit divider cells make up most of that path.
// A load updates the matrix at its accept edge, so it affects vertices that
// follow it and none before it.
// Reset clears the matrix to zero, sets divide_enable to 1 and empties the pipe.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops until the result is taken.
//
module vertex_transform_z_divide import vtzd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [3:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] vz,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_w,
    output logic               zero_divisor,
    output logic               overflowed
);

    logic  div_en_reg;
    logic  en;
    logic  in_fire;
    logic  chain_vld [DIV_STEPS+1];
    item_t chain_item [DIV_STEPS+1];

    logic        out_vld_reg;
    logic [31:0] res_reg [3];
    logic [31:0] res_next [3];
    logic [31:0] w_reg;
    logic        zdiv_reg;
    logic        ovf_reg;
    logic        ovf_next;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;
    assign in_fire  = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            div_en_reg <= cfg_wdata;
        end
    end

    vtzd_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_fire    (in_fire),
        .cmd        (cmd),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .vx         (vx),
        .vy         (vy),
        .vz         (vz),
        .div_en     (div_en_reg),
        .prep_vld   (chain_vld[0]),
        .prep_item  (chain_item[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        vtzd_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (chain_vld[i]),
            .in_item  (chain_item[i]),
            .out_vld  (chain_vld[i+1]),
            .out_item (chain_item[i+1])
        );
    end

    always_comb
    begin
        lane_t ln;
        ovf_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            ln = chain_item[DIV_STEPS].ln[c];
            if (ln.fixed)
            begin
                res_next[c] = ln.fixval;
                ovf_next    = ovf_next | ln.sat;
            end
            else if (ln.neg)
            begin
                if (ln.quo > 32'h8000_0000)
                begin
                    res_next[c] = S32_MIN;
                    ovf_next    = 1'b1;
                end
                else
                begin
                    res_next[c] = 32'(-ln.quo);
                end
            end
            else if (ln.quo[31])
            begin
                res_next[c] = S32_MAX;
                ovf_next    = 1'b1;
            end
            else
            begin
                res_next[c] = ln.quo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= chain_vld[DIV_STEPS];
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en && chain_vld[DIV_STEPS])
        begin
            res_reg  <= res_next;
            w_reg    <= chain_item[DIV_STEPS].w;
            zdiv_reg <= chain_item[DIV_STEPS].zdiv;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_x        = res_reg[0];
    assign out_y        = res_reg[1];
    assign out_z        = res_reg[2];
    assign out_w        = w_reg;
    assign zero_divisor = zdiv_reg;
    assign overflowed   = ovf_reg;

endmodule
